>>> hdl/usrd_pkg.sv
// Package with the types, codes and constants of the USB standard request decoder.
package usrd_pkg;

    localparam int ENDPOINT_COUNT_DEFAULT = 8;

    localparam int S_DATA_W = 48;
    localparam int M_DATA_W = 40;
    localparam int CFG_DATA_W = 4;

    // Actions.
    localparam logic [2:0] ACT_STALL    = 3'd0;
    localparam logic [2:0] ACT_ACK      = 3'd1;
    localparam logic [2:0] ACT_SEND     = 3'd2;
    localparam logic [2:0] ACT_SOFTWARE = 3'd3;
    localparam logic [2:0] ACT_NONE     = 3'd4;

    // Data stage kinds.
    localparam logic [3:0] KIND_NONE      = 4'd0;
    localparam logic [3:0] KIND_STATUS    = 4'd1;
    localparam logic [3:0] KIND_DEVICE    = 4'd2;
    localparam logic [3:0] KIND_LANGUAGE  = 4'd3;
    localparam logic [3:0] KIND_STRING    = 4'd4;
    localparam logic [3:0] KIND_CONFIG    = 4'd5;
    localparam logic [3:0] KIND_INTERFACE = 4'd6;
    localparam logic [3:0] KIND_ENDPOINT  = 4'd7;
    localparam logic [3:0] KIND_CONFBYTE  = 4'd8;

    // Request types and recipients.
    localparam logic [1:0] TYPE_STANDARD = 2'd0;
    localparam logic [1:0] TYPE_CLASS    = 2'd1;
    localparam logic [1:0] TYPE_VENDOR   = 2'd2;
    localparam logic [4:0] RCPT_DEVICE    = 5'd0;
    localparam logic [4:0] RCPT_INTERFACE = 5'd1;
    localparam logic [4:0] RCPT_ENDPOINT  = 5'd2;

    // Standard request codes.
    localparam logic [7:0] REQ_GET_STS        = 8'd0;
    localparam logic [7:0] REQ_CLR_FEATURE    = 8'd1;
    localparam logic [7:0] REQ_SET_FEAT       = 8'd3;
    localparam logic [7:0] REQ_SET_ADDR       = 8'd5;
    localparam logic [7:0] REQ_GET_DESCRIPTOR = 8'd6;
    localparam logic [7:0] REQ_SET_DESCRIPTOR = 8'd7;
    localparam logic [7:0] REQ_GET_CONFIG     = 8'd8;
    localparam logic [7:0] REQ_SET_CONFIG     = 8'd9;

    // Descriptor types.
    localparam logic [7:0] DESC_DEVICE    = 8'd1;
    localparam logic [7:0] DESC_CONFIG    = 8'd2;
    localparam logic [7:0] DESC_STRING    = 8'd3;
    localparam logic [7:0] DESC_INTERFACE = 8'd4;
    localparam logic [7:0] DESC_ENDPOINT  = 8'd5;

    localparam logic [2:0] MAX_BUNDLED_EP = 3'd6;

    // Configuration register indexes.
    localparam logic CFG_STRING_COUNT = 1'b0;
    localparam logic CFG_EP_DESC_COUNT = 1'b1;

    // Bus commands.
    localparam logic CMD_SETUP     = 1'b0;
    localparam logic CMD_BUS_RESET = 1'b1;

    typedef struct packed {
        logic [6:0] out_halt_mask;
        logic [6:0] in_halt_mask;
        logic       configured;
        logic       address_changed;
        logic [6:0] device_address;
        logic       direction_in;
        logic [7:0] data_value;
        logic [3:0] data_kind;
        logic [2:0] action;
    } result_t;

endpackage

>>> hdl/usb_standard_request_decoder_unit.sv
// Top level of the USB standard request decoder: input register, decode and result register.
// An item passes through the input register and the result register; an output stall holds both.
// Throughput: one item per cycle unless the output stalls; the decode between the input register
// and the result register reads and updates the address, configured and halt registers.
// Reset: rst_n clears the pipeline valids, the device state and both configuration registers.
module usb_standard_request_decoder_unit
    import usrd_pkg::*;
#(
    parameter int ENDPOINT_COUNT = ENDPOINT_COUNT_DEFAULT
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  s_tvalid,
    output logic                  s_tready,
    // request_type, request_code, request_value, request_index
    input  logic [S_DATA_W-1:0]   s_tdata,
    // command
    input  logic                  s_tuser,
    output logic                  m_tvalid,
    input  logic                  m_tready,
    // action, data_kind, data_value, direction_in, device_address, address_changed,
    // configured, in_halt_mask, out_halt_mask, one zero pad bit
    output logic [M_DATA_W-1:0]   m_tdata,
    input  logic                  cfg_we,
    input  logic                  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam logic [4:0] EP_LIMIT = 5'(ENDPOINT_COUNT);

    logic                in_vld_reg;
    logic                command_reg;
    logic [7:0]          rtype_reg;
    logic [7:0]          code_reg;
    logic [15:0]         value_reg;
    logic [15:0]         index_reg;
    logic                out_vld_reg;
    result_t             result_reg;
    result_t             result_next;
    logic [6:0]          bus_address_reg;
    logic [6:0]          bus_address_next;
    logic                configured_reg;
    logic                configured_next;
    logic [6:0]          in_halts_reg;
    logic [6:0]          in_halts_next;
    logic [6:0]          out_halts_reg;
    logic [6:0]          out_halts_next;
    logic [3:0]          string_count_reg;
    logic [2:0]          ep_desc_count_reg;
    logic                advance;
    logic                s_accept;

    logic [1:0]          req_kind;
    logic [4:0]          recipient;
    logic [7:0]          desc_type;
    logic [7:0]          desc_n;
    logic [7:0]          desc_n_m1;
    logic [3:0]          desc_ep;
    logic [3:0]          ep_num;
    logic                ep_ok;
    logic [6:0]          ep_bit;
    logic [2:0]          bundle_count;

    assign advance  = in_vld_reg && (!out_vld_reg || m_tready);
    assign s_tready = !in_vld_reg || advance;
    assign s_accept = s_tvalid && s_tready;
    assign m_tvalid = out_vld_reg;
    assign m_tdata  = {1'b0, result_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_vld_reg        <= 1'b0;
            out_vld_reg       <= 1'b0;
            bus_address_reg   <= '0;
            configured_reg    <= 1'b0;
            in_halts_reg      <= '0;
            out_halts_reg     <= '0;
            string_count_reg  <= '0;
            ep_desc_count_reg <= '0;
        end
        else
        begin
            if (s_accept)
            begin
                in_vld_reg <= 1'b1;
            end
            else if (advance)
            begin
                in_vld_reg <= 1'b0;
            end
            if (advance)
            begin
                out_vld_reg     <= 1'b1;
                bus_address_reg <= bus_address_next;
                configured_reg  <= configured_next;
                in_halts_reg    <= in_halts_next;
                out_halts_reg   <= out_halts_next;
            end
            else if (m_tready)
            begin
                out_vld_reg <= 1'b0;
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    CFG_STRING_COUNT:  string_count_reg  <= cfg_data;
                    CFG_EP_DESC_COUNT: ep_desc_count_reg <= cfg_data[2:0];
                    default:           string_count_reg  <= string_count_reg;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (s_accept)
        begin
            command_reg <= s_tuser;
            rtype_reg   <= s_tdata[7:0];
            code_reg    <= s_tdata[15:8];
            value_reg   <= s_tdata[31:16];
            index_reg   <= s_tdata[47:32];
        end
        if (advance)
        begin
            result_reg <= result_next;
        end
    end

    assign req_kind     = rtype_reg[6:5];
    assign recipient    = rtype_reg[4:0];
    assign desc_type    = value_reg[15:8];
    assign desc_n       = index_reg[7:0];
    assign desc_n_m1    = desc_n - 8'd1;
    assign desc_ep      = index_reg[3:0];
    assign ep_num       = index_reg[3:0];
    assign ep_ok        = (ep_num != 4'd0) && (ep_num <= 4'd7) && ({1'b0, ep_num} < EP_LIMIT);
    assign ep_bit       = 7'(7'd1 << (ep_num[2:0] - 3'd1));
    assign bundle_count = (ep_desc_count_reg > MAX_BUNDLED_EP) ? MAX_BUNDLED_EP
                                                                : ep_desc_count_reg;

    always_comb
    begin
        logic [2:0] act;
        logic [3:0] kind;
        logic [7:0] val;
        logic       chg;

        act              = ACT_NONE;
        kind             = KIND_NONE;
        val              = 8'd0;
        chg              = 1'b0;
        bus_address_next = bus_address_reg;
        configured_next  = configured_reg;
        in_halts_next    = in_halts_reg;
        out_halts_next   = out_halts_reg;

        if (command_reg == CMD_BUS_RESET)
        begin
            bus_address_next = '0;
            configured_next  = 1'b0;
            in_halts_next    = '0;
            out_halts_next   = '0;
        end
        else if (req_kind == TYPE_CLASS || req_kind == TYPE_VENDOR)
        begin
            act = ACT_SOFTWARE;
        end
        else if (req_kind != TYPE_STANDARD)
        begin
            act = ACT_STALL;
        end
        else if (recipient == RCPT_DEVICE)
        begin
            case (code_reg)
                REQ_GET_STS:
                begin
                    act  = ACT_SEND;
                    kind = KIND_STATUS;
                    val  = 8'd1;
                end
                REQ_SET_ADDR:
                begin
                    bus_address_next = value_reg[6:0];
                    chg              = 1'b1;
                    act              = ACT_ACK;
                end
                REQ_GET_DESCRIPTOR:
                begin
                    act = ACT_SEND;
                    case (desc_type)
                        DESC_DEVICE:
                        begin
                            kind = KIND_DEVICE;
                        end
                        DESC_CONFIG:
                        begin
                            kind = KIND_CONFIG;
                            val  = {5'd0, bundle_count};
                        end
                        DESC_STRING:
                        begin
                            if (desc_n == 8'd0)
                            begin
                                kind = KIND_LANGUAGE;
                            end
                            else if (desc_n_m1 >= {4'd0, string_count_reg})
                            begin
                                act = ACT_STALL;
                            end
                            else
                            begin
                                kind = KIND_STRING;
                                val  = desc_n_m1;
                            end
                        end
                        DESC_INTERFACE:
                        begin
                            kind = KIND_INTERFACE;
                        end
                        DESC_ENDPOINT:
                        begin
                            if (desc_ep == 4'd0 || desc_ep > {1'b0, ep_desc_count_reg})
                            begin
                                act = ACT_STALL;
                            end
                            else
                            begin
                                kind = KIND_ENDPOINT;
                                val  = {4'd0, desc_ep - 4'd1};
                            end
                        end
                        default:
                        begin
                            act = ACT_STALL;
                        end
                    endcase
                end
                REQ_GET_CONFIG:
                begin
                    act  = ACT_SEND;
                    kind = KIND_CONFBYTE;
                    val  = {7'd0, configured_reg};
                end
                REQ_SET_CONFIG:
                begin
                    if (value_reg[7:0] != 8'd1)
                    begin
                        act = ACT_STALL;
                    end
                    else
                    begin
                        configured_next = 1'b1;
                        act             = ACT_ACK;
                    end
                end
                REQ_CLR_FEATURE, REQ_SET_FEAT, REQ_SET_DESCRIPTOR:
                begin
                    act = ACT_STALL;
                end
                default:
                begin
                    act = ACT_SOFTWARE;
                end
            endcase
        end
        else if (recipient == RCPT_INTERFACE)
        begin
            if (code_reg == REQ_GET_STS)
            begin
                act  = ACT_SEND;
                kind = KIND_STATUS;
            end
            else
            begin
                act = ACT_STALL;
            end
        end
        else if (recipient == RCPT_ENDPOINT)
        begin
            if (code_reg == REQ_GET_STS)
            begin
                act  = ACT_SEND;
                kind = KIND_STATUS;
            end
            else if ((code_reg != REQ_CLR_FEATURE && code_reg != REQ_SET_FEAT)
                     || value_reg != 16'd0 || !ep_ok)
            begin
                act = ACT_STALL;
            end
            else
            begin
                act = ACT_ACK;
                if (index_reg[7])
                begin
                    in_halts_next = (code_reg == REQ_SET_FEAT) ? (in_halts_reg | ep_bit)
                                                               : (in_halts_reg & ~ep_bit);
                end
                else
                begin
                    out_halts_next = (code_reg == REQ_SET_FEAT) ? (out_halts_reg | ep_bit)
                                                                : (out_halts_reg & ~ep_bit);
                end
            end
        end
        else
        begin
            act = ACT_STALL;
        end

        if (act != ACT_SEND)
        begin
            kind = KIND_NONE;
            val  = 8'd0;
        end

        result_next.action          = act;
        result_next.data_kind       = kind;
        result_next.data_value      = val;
        result_next.direction_in    = (command_reg == CMD_SETUP) ? rtype_reg[7] : 1'b0;
        result_next.device_address  = bus_address_next;
        result_next.address_changed = chg;
        result_next.configured      = configured_next;
        result_next.in_halt_mask    = in_halts_next;
        result_next.out_halt_mask   = out_halts_next;
    end

endmodule

>>> hdl/usrd_checker.sv
// Port checker of the USB standard request decoder and its binding to the top level.
module usrd_checker
    import usrd_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                m_tvalid,
    input logic                m_tready,
    input logic [M_DATA_W-1:0] m_tdata
);

    result_t res;

    assign res = m_tdata[M_DATA_W-2:0];

    // A stalled result item holds.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("result item changed while stalled");

    // Only a data stage carries a kind and a value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.action != ACT_SEND |-> res.data_kind == KIND_NONE
                                              && res.data_value == 8'd0)
    else $error("data fields set without a data stage");

    // A bus reset leaves the device unaddressed, unconfigured and with no halts.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.action == ACT_NONE |-> res.device_address == 7'd0
            && !res.configured && res.in_halt_mask == 7'd0
            && res.out_halt_mask == 7'd0 && !res.direction_in)
    else $error("bus reset left device state behind");

    // An address change is always acknowledged.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && res.address_changed |-> res.action == ACT_ACK)
    else $error("address changed without an ack");

endmodule

bind usb_standard_request_decoder_unit usrd_checker u_usrd_checker
(
    .clk      (clk),
    .rst_n    (rst_n),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
